@@ rtl/core/rgb_median_filter_3x3_defines.svh @@
`ifndef RGB_MEDIAN_FILTER_3X3_DEFINES_SVH
`define RGB_MEDIAN_FILTER_3X3_DEFINES_SVH

// Assertion helpers for the median filter. Both forms are disabled while the
// active-low reset is asserted.

// The consequent must hold in the same cycle as the antecedent.
`define RMF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rmf_pkg.sv @@
package rmf_pkg;

  // Frame limits. Line store depth and counter widths follow from these.
  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 4096;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);

  // Register and bus widths.
  localparam int WidthRegW  = 12;
  localparam int HeightRegW = 13;
  localparam int AddrW      = 3;
  localparam int DataW      = 32;
  localparam int ChanW      = 8;

  localparam logic [WidthRegW-1:0]  WidthReset  = 12'd640;
  localparam logic [HeightRegW-1:0] HeightReset = 13'd480;

  typedef logic [ChanW-1:0] chan_t;

  // Blue sits in the low byte, red in the high byte.
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  localparam int PixW = $bits(pixel_t);

  typedef enum logic [0:0] {
    RegWidth  = 1'b0,
    RegHeight = 1'b1
  } reg_idx_e;

  // Effective frame size after clamping, one bit wider than the counters.
  typedef struct packed {
    logic [ColW:0] width;
    logic [RowW:0] height;
  } frame_size_t;

  // One accepted pixel with its 3x3 neighbourhood. Entry 8 is always the
  // pixel that was just accepted.
  typedef struct packed {
    pixel_t [8:0]    win;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            interior;
    logic            border;
  } item_t;

endpackage

@@ rtl/core/rmf_ram.sv @@
module rmf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Read-first: a read of the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/rmf_cfg.sv @@
module rmf_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rmf_pkg::AddrW-1:0]    paddr,
  input  logic [rmf_pkg::DataW-1:0]    pwdata,
  output logic [rmf_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  output rmf_pkg::frame_size_t         size_o
);

  logic [rmf_pkg::WidthRegW-1:0]  width_q, width_d;
  logic [rmf_pkg::HeightRegW-1:0] height_q, height_d;
  rmf_pkg::reg_idx_e              idx;
  logic                           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = rmf_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      unique case (idx)
        rmf_pkg::RegWidth:  width_d  = pwdata[rmf_pkg::WidthRegW-1:0];
        rmf_pkg::RegHeight: height_d = pwdata[rmf_pkg::HeightRegW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rmf_pkg::WidthReset;
      height_q <= rmf_pkg::HeightReset;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    unique case (idx)
      rmf_pkg::RegWidth:  prdata = rmf_pkg::DataW'(width_q);
      rmf_pkg::RegHeight: prdata = rmf_pkg::DataW'(height_q);
      default:            prdata = '0;
    endcase
  end

  // A size of zero acts as one; a width above the line store or a height above MaxHeight is clamped to that limit.
  always_comb begin
    if (width_q == '0) begin
      size_o.width = (rmf_pkg::ColW+1)'(1);
    end else if (32'(width_q) > rmf_pkg::MaxWidth) begin
      size_o.width = (rmf_pkg::ColW+1)'(rmf_pkg::MaxWidth);
    end else begin
      size_o.width = (rmf_pkg::ColW+1)'(width_q);
    end
    if (height_q == '0) begin
      size_o.height = (rmf_pkg::RowW+1)'(1);
    end else if (32'(height_q) > rmf_pkg::MaxHeight) begin
      size_o.height = (rmf_pkg::RowW+1)'(rmf_pkg::MaxHeight);
    end else begin
      size_o.height = (rmf_pkg::RowW+1)'(height_q);
    end
  end

endmodule

@@ rtl/core/rmf_median9.sv @@
module rmf_median9 (
  input  rmf_pkg::chan_t [8:0] vals_i,
  output rmf_pkg::chan_t       med_o
);

  function automatic rmf_pkg::chan_t min2(rmf_pkg::chan_t a, rmf_pkg::chan_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic rmf_pkg::chan_t max2(rmf_pkg::chan_t a, rmf_pkg::chan_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic rmf_pkg::chan_t med3(rmf_pkg::chan_t a, rmf_pkg::chan_t b,
                                          rmf_pkg::chan_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  rmf_pkg::chan_t lo [3];
  rmf_pkg::chan_t mi [3];
  rmf_pkg::chan_t hi [3];

  // Sort each group of three, then the median of nine is the median of the
  // largest low, the middle middle and the smallest high.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo[k] = min2(vals_i[3*k], min2(vals_i[3*k+1], vals_i[3*k+2]));
      hi[k] = max2(vals_i[3*k], max2(vals_i[3*k+1], vals_i[3*k+2]));
      mi[k] = med3(vals_i[3*k], vals_i[3*k+1], vals_i[3*k+2]);
    end
    med_o = med3(max2(lo[0], max2(lo[1], lo[2])),
                 med3(mi[0], mi[1], mi[2]),
                 min2(hi[0], min2(hi[1], hi[2])));
  end

endmodule

@@ rtl/core/rmf_window.sv @@
module rmf_window (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  rmf_pkg::pixel_t      pixel_i,
  input  rmf_pkg::frame_size_t size_i,
  output rmf_pkg::item_t       item_o
);

  logic [rmf_pkg::RowW-1:0] row_q, row_d;
  logic [rmf_pkg::ColW-1:0] col_q, col_d;
  rmf_pkg::pixel_t [5:0]    win_q, win_d;
  logic                     bypass_q, bypass_d;
  rmf_pkg::pixel_t [1:0]    bypass_data_q;
  rmf_pkg::pixel_t [1:0]    rd_data;
  rmf_pkg::pixel_t [1:0]    wr_data;
  rmf_pkg::pixel_t          top;
  rmf_pkg::pixel_t          mid;
  logic                     col_last;
  logic                     row_last;

  // Entry 1 is the row two above, entry 0 the row above.
  rmf_ram #(
    .Width (2 * rmf_pkg::PixW),
    .Depth (rmf_pkg::MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (accept_i),
    .waddr_i (col_q),
    .wdata_i (wr_data),
    .raddr_i (col_d),
    .rdata_o (rd_data)
  );

  // The RAM reads the column of the next pixel ahead of time. When that is
  // the column just written (one-pixel rows), the written word is forwarded.
  assign top     = bypass_q ? bypass_data_q[1] : rd_data[1];
  assign mid     = bypass_q ? bypass_data_q[0] : rd_data[0];
  assign wr_data = {mid, pixel_i};

  assign col_last = ((rmf_pkg::ColW+1)'(col_q) + (rmf_pkg::ColW+1)'(1)) >= size_i.width;
  assign row_last = ((rmf_pkg::RowW+1)'(row_q) + (rmf_pkg::RowW+1)'(1)) >= size_i.height;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    win_d = win_q;
    if (accept_i) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + rmf_pkg::RowW'(1);
      end else begin
        col_d = col_q + rmf_pkg::ColW'(1);
      end
      win_d[3] = win_q[0];
      win_d[4] = win_q[1];
      win_d[5] = win_q[2];
      win_d[0] = top;
      win_d[1] = mid;
      win_d[2] = pixel_i;
    end
    bypass_d = accept_i && (col_d == col_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      win_q    <= '0;
      bypass_q <= 1'b0;
    end else begin
      row_q    <= row_d;
      col_q    <= col_d;
      win_q    <= win_d;
      bypass_q <= bypass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bypass_data_q <= wr_data;
  end

  always_comb begin
    item_o.win[0]   = win_q[3];
    item_o.win[1]   = win_q[0];
    item_o.win[2]   = top;
    item_o.win[3]   = win_q[4];
    item_o.win[4]   = win_q[1];
    item_o.win[5]   = mid;
    item_o.win[6]   = win_q[5];
    item_o.win[7]   = win_q[2];
    item_o.win[8]   = pixel_i;
    item_o.row      = row_q;
    item_o.col      = col_q;
    item_o.interior = (row_q >= rmf_pkg::RowW'(2)) && (col_q >= rmf_pkg::ColW'(2));
    item_o.border   = (row_q == '0) || (col_q == '0) ||
                      ((rmf_pkg::RowW+1)'(row_q) >= size_i.height - (rmf_pkg::RowW+1)'(1)) ||
                      ((rmf_pkg::ColW+1)'(col_q) >= size_i.width - (rmf_pkg::ColW+1)'(1));
  end

endmodule

@@ rtl/core/rgb_median_filter_3x3.sv @@
// A word reaches out_valid_o through the first-stage register and then the output register after
// its pixel is accepted; a border word that follows its pixel's interior word is registered after that word.
// Throughput: one pixel word per cycle unless the output stalls; a pixel with an interior and a
// border word holds the input while both are owed, as the output takes one word per cycle.
// Reset: counters, window and handshake state clear at once, sizes return to 640 x 480;
// the line stores are not cleared, so no clearing pass runs and the first word is taken at once.

`include "rgb_median_filter_3x3_defines.svh"

module rgb_median_filter_3x3 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rmf_pkg::AddrW-1:0] paddr,
  input  logic [rmf_pkg::DataW-1:0] pwdata,
  output logic [rmf_pkg::DataW-1:0] prdata,
  output logic                      pready,
  // Pixel input channel.
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  rmf_pkg::chan_t            blue_in_i,
  input  rmf_pkg::chan_t            green_in_i,
  input  rmf_pkg::chan_t            red_in_i,
  // Result channel.
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output rmf_pkg::chan_t            blue_out_o,
  output rmf_pkg::chan_t            green_out_o,
  output rmf_pkg::chan_t            red_out_o,
  output logic [rmf_pkg::RowW-1:0]  out_row_o,
  output logic [rmf_pkg::ColW-1:0]  out_col_o,
  output logic                      is_border_o,
  output logic                      last_o
);

  // The design has two register stages. The first holds the accepted pixel
  // together with its full 3x3 neighbourhood, taken from the line RAM and
  // the window registers as the pixel enters. The second is the output
  // register. Between them sit the three per-channel median networks and
  // the selection between the interior word and the border word.

  rmf_pkg::frame_size_t size;
  rmf_pkg::item_t       item;
  rmf_pkg::pixel_t      pixel_in;
  logic                 accept;

  rmf_pkg::item_t       s1_q, s1_d;
  logic                 s1_valid_q, s1_valid_d;
  logic                 pend_int_q, pend_int_d;
  logic                 pend_bord_q, pend_bord_d;

  logic                 out_free;
  logic                 emit;
  logic                 s1_done;

  rmf_pkg::chan_t [8:0] blue_win;
  rmf_pkg::chan_t [8:0] green_win;
  rmf_pkg::chan_t [8:0] red_win;
  rmf_pkg::pixel_t      med;

  logic                     out_valid_q, out_valid_d;
  rmf_pkg::pixel_t          out_pix_q, out_pix_d;
  logic [rmf_pkg::RowW-1:0] out_row_q, out_row_d;
  logic [rmf_pkg::ColW-1:0] out_col_q, out_col_d;
  logic                     out_border_q, out_border_d;
  logic                     out_last_q, out_last_d;

  logic                     med_word;
  logic                     med_off_edge;
  logic                     first_taken;
  logic                     pair_border;

  rmf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size_o  (size)
  );

  assign pixel_in = '{red: red_in_i, green: green_in_i, blue: blue_in_i};

  // Counters, line RAM and window columns advance on every accepted word.
  rmf_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .pixel_i  (pixel_in),
    .size_i   (size),
    .item_o   (item)
  );

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      blue_win[i]  = s1_q.win[i].blue;
      green_win[i] = s1_q.win[i].green;
      red_win[i]   = s1_q.win[i].red;
    end
  end

  rmf_median9 u_med_blue  (.vals_i(blue_win),  .med_o(med.blue));
  rmf_median9 u_med_green (.vals_i(green_win), .med_o(med.green));
  rmf_median9 u_med_red   (.vals_i(red_win),   .med_o(med.red));

  // The first stage is valid only while it still owes a word, so a valid
  // stage always has at least one pending result. It is free in a cycle in
  // which its last pending word moves into the output register, which lets
  // a new pixel enter while the output waits on the far side.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = s1_valid_q && out_free;
  assign s1_done    = !s1_valid_q || (out_free && !(pend_int_q && pend_bord_q));
  assign in_stall_o = !s1_done;
  assign accept     = in_valid_i && s1_done;

  always_comb begin
    s1_d        = s1_q;
    s1_valid_d  = s1_valid_q;
    pend_int_d  = pend_int_q;
    pend_bord_d = pend_bord_q;
    if (emit) begin
      if (pend_int_q) begin
        pend_int_d = 1'b0;
        s1_valid_d = pend_bord_q;
      end else begin
        pend_bord_d = 1'b0;
        s1_valid_d  = 1'b0;
      end
    end
    if (accept) begin
      s1_d        = item;
      s1_valid_d  = item.interior || item.border;
      pend_int_d  = item.interior;
      pend_bord_d = item.border;
    end
  end

  // The interior word of a pixel always goes before its border word. The
  // interior word describes the pixel up and to the left of the newest one.
  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    out_pix_d    = out_pix_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    out_border_d = out_border_q;
    out_last_d   = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (pend_int_q) begin
        out_pix_d    = med;
        out_row_d    = s1_q.row - rmf_pkg::RowW'(1);
        out_col_d    = s1_q.col - rmf_pkg::ColW'(1);
        out_border_d = 1'b0;
        out_last_d   = !pend_bord_q;
      end else begin
        out_pix_d    = s1_q.win[8];
        out_row_d    = s1_q.row;
        out_col_d    = s1_q.col;
        out_border_d = 1'b1;
        out_last_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      pend_int_q  <= 1'b0;
      pend_bord_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      pend_int_q  <= pend_int_d;
      pend_bord_q <= pend_bord_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q         <= s1_d;
    out_pix_q    <= out_pix_d;
    out_row_q    <= out_row_d;
    out_col_q    <= out_col_d;
    out_border_q <= out_border_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign blue_out_o  = out_pix_q.blue;
  assign green_out_o = out_pix_q.green;
  assign red_out_o   = out_pix_q.red;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign is_border_o = out_border_q;
  assign last_o      = out_last_q;

  assign med_word     = out_valid_o && !is_border_o;
  assign med_off_edge = (out_row_o != '0) && (out_col_o != '0);
  assign first_taken  = out_valid_o && !last_o && !out_stall_i;
  assign pair_border  = out_valid_o && is_border_o && last_o;

  // A median word never lies on the first row or column of the frame.
  `RMF_ASSERT_NOW(a_interior_off_edge, clk_i, rst_ni, med_word, med_off_edge, "median on edge")

  // A word that is not the last of its pixel is followed at once by that pixel's border word.
  `RMF_ASSERT_NEXT(a_pair_follows, clk_i, rst_ni, first_taken, pair_border, "border word missing")

  // The first stage never holds a pixel that owes no word.
  `RMF_ASSERT_NOW(a_stage_pending, clk_i, rst_ni, s1_valid_q, pend_int_q || pend_bord_q, "idle hold")

endmodule

@@ sim/tb_rgb_median_filter_3x3.sv @@
module tb_rgb_median_filter_3x3;
  import rmf_pkg::*;

  // The watchdog gives up after this many cycles with work pending and no word
  // moving on either channel. Stalls at 67 percent never come near it.
  localparam int WatchdogLimit = 5000;
  // Cycles allowed after the last expected word before a register write or the
  // end of the run. This covers pixels that give no word but are still in flight.
  localparam int DrainCycles   = 8;
  localparam int RandomItems   = 950;

  // Ways the sender and the receiver hold back.
  typedef enum int {IdleNone, IdleSrc, IdleSnk, IdleBoth} idle_mode_e;
  // Ways pixel values are drawn.
  typedef enum int {PatRandom, PatExtreme, PatTies} pattern_e;

  // One result word as it should appear on the output channel.
  typedef struct packed {
    chan_t           blue;
    chan_t           green;
    chan_t           red;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            border;
    logic            last;
  } result_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [AddrW-1:0]  paddr       = '0;
  logic [DataW-1:0]  pwdata      = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  chan_t             blue_in_i   = '0;
  chan_t             green_in_i  = '0;
  chan_t             red_in_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  chan_t             blue_out_o;
  chan_t             green_out_o;
  chan_t             red_out_o;
  logic [RowW-1:0]   out_row_o;
  logic [ColW-1:0]   out_col_o;
  logic              is_border_o;
  logic              last_o;

  rgb_median_filter_3x3 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .blue_in_i   (blue_in_i),
    .green_in_i  (green_in_i),
    .red_in_i    (red_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .blue_out_o  (blue_out_o),
    .green_out_o (green_out_o),
    .red_out_o   (red_out_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .is_border_o (is_border_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pixels waiting to be offered, and result words the filter still owes us.
  pixel_t  pixel_q[$];
  result_t awaited_words[$];

  int err_count     = 0;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;

  // Our own copy of the filter state. The size registers mirror what was written
  // over the configuration port; the rest follows the accepted pixel stream.
  logic [WidthRegW-1:0]  width_reg  = WidthReset;
  logic [HeightRegW-1:0] height_reg = HeightReset;
  int                    next_row   = 0;
  int                    next_col   = 0;
  pixel_t                line_two_up [MaxWidth];
  pixel_t                line_one_up [MaxWidth];
  // Entries 0..2 are the column just left of the current pixel (top, middle,
  // bottom), entries 3..5 the column two to the left.
  pixel_t                window_hist [6];

  initial begin
    for (int i = 0; i < 6; i++) window_hist[i] = '0;
  end

  // A size of zero acts as one, and anything above the line store depth or the
  // row limit is clamped to it.
  function automatic int eff_dim(input int v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Fifth smallest of one channel across the nine pixels of the neighborhood.
  function automatic chan_t median9(input pixel_t [8:0] nb, input int sh);
    chan_t a [9];
    chan_t k;
    int    j;
    for (int i = 0; i < 9; i++) a[i] = chan_t'(nb[i] >> sh);
    for (int i = 1; i < 9; i++) begin
      k = a[i];
      j = i - 1;
      while (j >= 0 && a[j] > k) begin
        a[j + 1] = a[j];
        j--;
      end
      a[j + 1] = k;
    end
    return a[4];
  endfunction

  // Works out the words that one accepted pixel produces and advances our copy
  // of the counters, the line stores and the window.
  task automatic filter_pixel(input pixel_t px);
    int           w;
    int           h;
    int           r;
    int           c;
    pixel_t       above2;
    pixel_t       above1;
    pixel_t [8:0] nb;
    result_t      res;
    logic         on_edge;
    w       = eff_dim(int'(width_reg), MaxWidth);
    h       = eff_dim(int'(height_reg), MaxHeight);
    r       = next_row;
    c       = next_col;
    above2  = line_two_up[c % MaxWidth];
    above1  = line_one_up[c % MaxWidth];
    // Counters left past the size by a mid-frame shrink still count as border.
    on_edge = (r == 0) || (c == 0) || (r >= h - 1) || (c >= w - 1);

    // The pixel diagonally up and to the left is finished once this one is in.
    // No size test here: row and column of at least two is all it takes.
    if (r >= 2 && c >= 2) begin
      nb[0] = window_hist[3];
      nb[1] = window_hist[0];
      nb[2] = above2;
      nb[3] = window_hist[4];
      nb[4] = window_hist[1];
      nb[5] = above1;
      nb[6] = window_hist[5];
      nb[7] = window_hist[2];
      nb[8] = px;
      res.blue   = median9(nb, 0);
      res.green  = median9(nb, ChanW);
      res.red    = median9(nb, 2 * ChanW);
      res.row    = RowW'(r - 1);
      res.col    = ColW'(c - 1);
      res.border = 1'b0;
      res.last   = !on_edge;
      awaited_words.insert(awaited_words.size(), res);
    end
    // Border pixels pass through unchanged, after any interior word.
    if (on_edge) begin
      res.blue   = px.blue;
      res.green  = px.green;
      res.red    = px.red;
      res.row    = RowW'(r);
      res.col    = ColW'(c);
      res.border = 1'b1;
      res.last   = 1'b1;
      awaited_words.insert(awaited_words.size(), res);
    end

    line_two_up[c % MaxWidth] = above1;
    line_one_up[c % MaxWidth] = px;
    window_hist[3] = window_hist[0];
    window_hist[4] = window_hist[1];
    window_hist[5] = window_hist[2];
    window_hist[0] = above2;
    window_hist[1] = above1;
    window_hist[2] = px;

    // The column wraps at the end of the row, and the row wraps at the end of
    // the frame.
    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
  endtask

  // Number of pixels that brings the counters back to the top left corner.
  function automatic int frame_rest();
    int w;
    int h;
    int n;
    w = eff_dim(int'(width_reg), MaxWidth);
    h = eff_dim(int'(height_reg), MaxHeight);
    n = (next_col >= w) ? 1 : w - next_col;
    if (next_row + 1 < h) n += (h - next_row - 1) * w;
    return n;
  endfunction

  function automatic pixel_t next_pixel(input pattern_e pat);
    pixel_t px;
    case (pat)
      PatExtreme: begin
        px.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
        px.green = $urandom_range(1) ? 8'hFF : 8'h00;
        px.red   = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      PatTies: begin
        // A handful of values, so that the median often sits among equal ones.
        px.blue  = chan_t'($urandom_range(3) * 85);
        px.green = chan_t'($urandom_range(3) * 85);
        px.red   = chan_t'($urandom_range(3) * 85);
      end
      default: begin
        px.blue  = chan_t'($urandom_range(255));
        px.green = chan_t'($urandom_range(255));
        px.red   = chan_t'($urandom_range(255));
      end
    endcase
    return px;
  endfunction

  task automatic queue_pixels(input int n, input pattern_e pat);
    for (int i = 0; i < n; i++) pixel_q.insert(pixel_q.size(), next_pixel(pat));
  endtask

  task automatic set_idle(input idle_mode_e mode);
    src_idle_pct  = (mode == IdleSrc) ? 67 : (mode == IdleBoth) ? 10 : 0;
    snk_stall_pct = (mode == IdleSnk) ? 67 : (mode == IdleBoth) ? 10 : 0;
  endtask

  // Waits until every queued pixel has gone in and every word owed has come out,
  // then lets the pipeline settle.
  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_valid_i || awaited_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One write over the configuration port: a setup phase, then an access phase
  // that completes at the edge where pready is seen high.
  task automatic apb_write(input reg_idx_e idx, input int val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegWidth:  width_reg  = WidthRegW'(val);
      RegHeight: height_reg = HeightRegW'(val);
      default: ;
    endcase
  endtask

  task automatic set_frame_size(input int wv, input int hv);
    apb_write(RegWidth, wv);
    apb_write(RegHeight, hv);
  endtask

  // Sizes for the random frames: mostly small, with zero, one and two, too small to leave
  // an interior, showing up often.
  function automatic int pick_dim(input int maxv);
    int sel;
    sel = $urandom_range(9);
    if (sel <= 2) return sel;
    return $urandom_range(3, maxv);
  endfunction

  // Sender side. A new pixel is offered only when the current word has gone in
  // or none is offered, so a stalled word never changes. The accepted word is
  // handed to the predictor at the edge that takes it.
  always @(posedge clk_i) begin : drive_pixels
    pixel_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) filter_pixel({red_in_i, green_in_i, blue_in_i});
      if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pixel_q.pop_front();
        in_valid_i <= 1'b1;
        blue_in_i  <= nxt.blue;
        green_in_i <= nxt.green;
        red_in_i   <= nxt.red;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  task automatic check_field(input string what, input logic [31:0] expv,
                             input logic [31:0] actv);
    if (actv !== expv) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, expv, actv);
      err_count++;
    end
  endtask

  // Receiver side. Each word taken is compared field by field with the oldest
  // word still owed; the stall for the next cycle is drawn afresh every edge.
  always @(posedge clk_i) begin : check_words
    result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_words.size() == 0) begin
          $display("%0t: unexpected word at row %0d col %0d, expected none",
                   $time, out_row_o, out_col_o);
          err_count++;
        end else begin
          want = awaited_words.pop_front();
          check_field("blue", 32'(want.blue), 32'(blue_out_o));
          check_field("green", 32'(want.green), 32'(green_out_o));
          check_field("red", 32'(want.red), 32'(red_out_o));
          check_field("row", 32'(want.row), 32'(out_row_o));
          check_field("col", 32'(want.col), 32'(out_col_o));
          check_field("is_border", 32'(want.border), 32'(is_border_o));
          check_field("last", 32'(want.last), 32'(last_o));
        end
      end
      out_stall_i <= ($urandom_range(99) < snk_stall_pct);
    end
  end

  // Watchdog: only cycles with work pending and nothing moving count.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (pixel_q.size() != 0 || in_valid_i || awaited_words.size() != 0) begin
      if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int       fed;
    int       span;
    int       k;
    int       frame_idx;
    pattern_e pat;
    pixel_t   px;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The smallest frame with an interior, with channels at
    // both ends of their range so the single median is easy to get wrong.
    set_idle(IdleNone);
    set_frame_size(3, 3);
    for (int i = 0; i < 9; i++) begin
      px.blue  = (i % 2 != 0) ? 8'hFF : 8'h00;
      px.green = (i < 4) ? 8'hFF : 8'h00;
      px.red   = (i == 8) ? 8'hFF : chan_t'(i * 29);
      pixel_q.insert(pixel_q.size(), px);
    end
    wait_drained();

    // Zero sizes act as a one by one frame: every pixel is a border word of its
    // own and the frame wraps after each one.
    set_frame_size(0, 0);
    queue_pixels(3, PatExtreme);
    wait_drained();

    // Width shrunk in mid-frame, leaving the column counter past the new size.
    // The pixel there counts as border, the interior rule still applies, and
    // the column counter wraps on the next advance.
    set_frame_size(5, 5);
    queue_pixels(19, PatRandom);
    wait_drained();
    apb_write(RegWidth, 3);
    queue_pixels(frame_rest(), PatRandom);
    wait_drained();

    // Random frames. Now and then a frame is cut short and shrunk in the middle,
    // in width, height or both. Sizes only ever grow at a frame boundary, so
    // the line stores are always filled before the window reads them.
    fed       = 0;
    frame_idx = 0;
    while (fed < RandomItems) begin
      case ((frame_idx / 3) % 4)
        0:       set_idle(IdleNone);
        1:       set_idle(IdleSrc);
        2:       set_idle(IdleSnk);
        default: set_idle(IdleBoth);
      endcase
      set_frame_size(pick_dim(12), pick_dim(10));
      pat  = ($urandom_range(3) == 0) ? PatTies : PatRandom;
      span = frame_rest();
      if (span >= 4 && $urandom_range(3) == 0) begin
        k = $urandom_range(1, span - 1);
        queue_pixels(k, pat);
        wait_drained();
        fed += k;
        apb_write(RegWidth, int'($urandom_range(0, eff_dim(int'(width_reg), MaxWidth))));
        apb_write(RegHeight, int'($urandom_range(0, eff_dim(int'(height_reg), MaxHeight))));
        span = frame_rest();
      end
      queue_pixels(span, pat);
      wait_drained();
      fed += span;
      frame_idx++;
    end

    // Oversized registers at a frame boundary, then a shrink in mid-frame that
    // leaves the column counter far past the new width and ends the frame after
    // two short rows.
    set_idle(IdleBoth);
    set_frame_size(4095, 8191);
    queue_pixels(20, PatRandom);
    wait_drained();
    set_frame_size(4, 3);
    queue_pixels(frame_rest(), PatExtreme);
    wait_drained();

    if (err_count == 0 && awaited_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rmf_pkg.sv
rtl/core/rmf_ram.sv
rtl/core/rmf_cfg.sv
rtl/core/rmf_median9.sv
rtl/core/rmf_window.sv
rtl/core/rgb_median_filter_3x3.sv
sim/tb_rgb_median_filter_3x3.sv
